### rtl/canmq_pkg.sv
// Shared types, codes and helper functions for the CAN message queue engine.
package canmq_pkg;

    // Default ring depths; each ring holds depth minus one messages.
    localparam int RX_DEPTH_DEF = 16;
    localparam int TX_DEPTH_DEF = 16;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_TX_DONE = 2'd1;
    localparam logic [1:0] ACT_RECEIVE = 2'd2;
    localparam logic [1:0] ACT_READ = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_LOADED = 3'd0;
    localparam logic [2:0] KIND_QUEUED = 3'd1;
    localparam logic [2:0] KIND_NOTHING = 3'd2;
    localparam logic [2:0] KIND_STORED = 3'd3;
    localparam logic [2:0] KIND_READ = 3'd4;
    localparam logic [2:0] KIND_EMPTY = 3'd5;

    localparam int HDR_W = 35;
    localparam int PAY_W = 64;
    localparam int ENTRY_W = HDR_W + PAY_W;

    typedef struct packed {
        logic [1:0]  action;
        logic [28:0] ident;
        logic        extended;
        logic        remote;
        logic [3:0]  length;
        logic [31:0] data_low;
        logic [31:0] data_high;
        logic [31:0] raw_id_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] ident_word;
        logic [28:0] out_ident;
        logic        out_extended;
        logic        out_remote;
        logic [3:0]  out_length;
        logic [31:0] out_data_low;
        logic [31:0] out_data_high;
        logic        rx_overflow;
        logic        tx_overflow;
    } out_item_t;

    // Message header as kept in the ring memories.
    typedef struct packed {
        logic [3:0]  length;
        logic        remote;
        logic        extended;
        logic [28:0] ident;
    } hdr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // Build the packed mailbox identifier word, request bit set.
    function automatic logic [31:0] pack_word(input hdr_t hdr);
        logic [31:0] w;
        if (hdr.extended) begin
            w = {hdr.ident, 3'b100};
        end else begin
            w = {hdr.ident[10:0], 21'd0};
        end
        w[1] = w[1] | hdr.remote;
        w[0] = 1'b1;
        return w;
    endfunction

    // Decode a raw received mailbox identifier word into a header.
    function automatic hdr_t decode_raw(input logic [31:0] raw, input logic [3:0] len);
        hdr_t hdr;
        hdr.extended = raw[2];
        hdr.remote = raw[1];
        hdr.length = len;
        if (raw[2]) begin
            hdr.ident = raw[31:3];
        end else begin
            hdr.ident = {18'd0, raw[31:21]};
        end
        return hdr;
    endfunction

endpackage

### rtl/can_message_queue_engine_core.sv
// Top level: transmit mailbox, transmit ring and receive ring for CAN messages.
// Each result is registered in the pending result register and then in the output register;
// a transaction that pops a ring (transmit done or software read) passes the fetch state first.
// Throughput: one transaction per cycle without a ring pop while the output is not stalled; a pop
// holds off new transactions during the fetch state, which waits for the registered ring memory read.
// Reset (aresetn, synchronous, active low) clears ring pointers, mailbox state,
// overflow flags and handshakes; ring memory contents are not cleared.
module can_message_queue_engine_core
    import canmq_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    state_t state_reg, state_next;
    logic [RX_AW-1:0] rx_wpos_reg, rx_wpos_next, rx_rpos_reg, rx_rpos_next;
    logic [TX_AW-1:0] tx_wpos_reg, tx_wpos_next, tx_rpos_reg, tx_rpos_next;
    logic mbox_busy_reg, mbox_busy_next;
    logic rx_ovf_reg, rx_ovf_next, tx_ovf_reg, tx_ovf_next;
    logic fetch_tx_reg, fetch_tx_next;
    out_item_t res_reg, res_next;
    logic m_valid_reg;
    out_item_t m_item_reg;

    logic accept, out_free, need_fetch;
    logic [RX_AW-1:0] rx_wpos_inc, rx_rpos_inc;
    logic [TX_AW-1:0] tx_wpos_inc, tx_rpos_inc;
    logic rx_empty, rx_full, tx_empty, tx_full;
    logic rx_we, tx_we, rx_re, tx_re;
    hdr_t send_hdr, recv_hdr, fetch_hdr;
    logic [PAY_W-1:0] in_pay, fetch_pay;
    logic [ENTRY_W-1:0] rx_rd_data, tx_rd_data, fetch_entry;

    // Handshake terms.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE) || ((state_reg == ST_EMIT) && out_free);
    assign accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item = m_item_reg;

    // Ring pointer arithmetic with wrap at the configured depth.
    assign rx_wpos_inc = (rx_wpos_reg == RX_LAST) ? '0 : rx_wpos_reg + 1'b1;
    assign rx_rpos_inc = (rx_rpos_reg == RX_LAST) ? '0 : rx_rpos_reg + 1'b1;
    assign tx_wpos_inc = (tx_wpos_reg == TX_LAST) ? '0 : tx_wpos_reg + 1'b1;
    assign tx_rpos_inc = (tx_rpos_reg == TX_LAST) ? '0 : tx_rpos_reg + 1'b1;
    assign rx_empty = (rx_wpos_reg == rx_rpos_reg);
    assign tx_empty = (tx_wpos_reg == tx_rpos_reg);
    assign rx_full = (rx_wpos_inc == rx_rpos_reg);
    assign tx_full = (tx_wpos_inc == tx_rpos_reg);

    // Incoming message header and payload.
    assign send_hdr = '{length: s_item.length, remote: s_item.remote,
                        extended: s_item.extended, ident: s_item.ident};
    assign recv_hdr = decode_raw(s_item.raw_id_word, s_item.length);
    assign in_pay = {s_item.data_high, s_item.data_low};

    // Entry read back from the ring selected at accept time.
    assign fetch_entry = fetch_tx_reg ? tx_rd_data : rx_rd_data;
    assign fetch_hdr = hdr_t'(fetch_entry[ENTRY_W-1:PAY_W]);
    assign fetch_pay = fetch_entry[PAY_W-1:0];

    // Ring memories, one entry holds header and payload.
    canmq_ram #(.WIDTH(ENTRY_W), .DEPTH(TX_DEPTH)) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_we),
        .wr_addr (tx_wpos_reg),
        .wr_data ({send_hdr, in_pay}),
        .rd_en   (tx_re),
        .rd_addr (tx_rpos_reg),
        .rd_data (tx_rd_data)
    );

    canmq_ram #(.WIDTH(ENTRY_W), .DEPTH(RX_DEPTH)) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_we),
        .wr_addr (rx_wpos_reg),
        .wr_data ({recv_hdr, in_pay}),
        .rd_en   (rx_re),
        .rd_addr (rx_rpos_reg),
        .rd_data (rx_rd_data)
    );

    // Transaction processing: pointer updates, memory access and result building.
    always_comb begin
        rx_wpos_next = rx_wpos_reg;
        rx_rpos_next = rx_rpos_reg;
        tx_wpos_next = tx_wpos_reg;
        tx_rpos_next = tx_rpos_reg;
        mbox_busy_next = mbox_busy_reg;
        rx_ovf_next = rx_ovf_reg;
        tx_ovf_next = tx_ovf_reg;
        fetch_tx_next = fetch_tx_reg;
        res_next = res_reg;
        need_fetch = 1'b0;
        rx_we = 1'b0;
        tx_we = 1'b0;
        rx_re = 1'b0;
        tx_re = 1'b0;
        if (accept) begin
            res_next = '0;
            unique case (s_item.action)
                ACT_SEND: begin
                    if (!mbox_busy_reg) begin
                        mbox_busy_next = 1'b1;
                        res_next.kind = KIND_LOADED;
                        res_next.ident_word = pack_word(send_hdr);
                        res_next.out_ident = send_hdr.ident;
                        res_next.out_extended = send_hdr.extended;
                        res_next.out_remote = send_hdr.remote;
                        res_next.out_length = send_hdr.length;
                        res_next.out_data_low = s_item.data_low;
                        res_next.out_data_high = s_item.data_high;
                    end else begin
                        res_next.kind = KIND_QUEUED;
                        if (tx_full) begin
                            tx_ovf_next = 1'b1;
                        end else begin
                            tx_we = 1'b1;
                            tx_wpos_next = tx_wpos_inc;
                        end
                    end
                end
                ACT_TX_DONE: begin
                    if (!tx_empty) begin
                        tx_re = 1'b1;
                        tx_rpos_next = tx_rpos_inc;
                        mbox_busy_next = 1'b1;
                        need_fetch = 1'b1;
                        fetch_tx_next = 1'b1;
                        res_next.kind = KIND_LOADED;
                    end else begin
                        mbox_busy_next = 1'b0;
                        res_next.kind = KIND_NOTHING;
                    end
                end
                ACT_RECEIVE: begin
                    res_next.kind = KIND_STORED;
                    if (rx_full) begin
                        rx_ovf_next = 1'b1;
                    end else begin
                        rx_we = 1'b1;
                        rx_wpos_next = rx_wpos_inc;
                    end
                end
                ACT_READ: begin
                    if (!rx_empty) begin
                        rx_re = 1'b1;
                        rx_rpos_next = rx_rpos_inc;
                        need_fetch = 1'b1;
                        fetch_tx_next = 1'b0;
                        res_next.kind = KIND_READ;
                    end else begin
                        res_next.kind = KIND_EMPTY;
                    end
                end
                default: begin
                    res_next.kind = KIND_EMPTY;
                end
            endcase
            res_next.rx_overflow = rx_ovf_next;
            res_next.tx_overflow = tx_ovf_next;
        end else if (state_reg == ST_FETCH) begin
            // Merge the message popped from the ring into the pending result.
            res_next.out_ident = fetch_hdr.ident;
            res_next.out_extended = fetch_hdr.extended;
            res_next.out_remote = fetch_hdr.remote;
            res_next.out_length = fetch_hdr.length;
            res_next.out_data_low = fetch_pay[31:0];
            res_next.out_data_high = fetch_pay[63:32];
            if (fetch_tx_reg) begin
                res_next.ident_word = pack_word(fetch_hdr);
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = need_fetch ? ST_FETCH : ST_EMIT;
                end
            end
            ST_FETCH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (accept) begin
                    state_next = need_fetch ? ST_FETCH : ST_EMIT;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rx_wpos_reg <= '0;
            rx_rpos_reg <= '0;
            tx_wpos_reg <= '0;
            tx_rpos_reg <= '0;
            mbox_busy_reg <= 1'b0;
            rx_ovf_reg <= 1'b0;
            tx_ovf_reg <= 1'b0;
            fetch_tx_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rx_wpos_reg <= rx_wpos_next;
            rx_rpos_reg <= rx_rpos_next;
            tx_wpos_reg <= tx_wpos_next;
            tx_rpos_reg <= tx_rpos_next;
            mbox_busy_reg <= mbox_busy_next;
            rx_ovf_reg <= rx_ovf_next;
            tx_ovf_reg <= tx_ovf_next;
            fetch_tx_reg <= fetch_tx_next;
        end
    end

    // Pending result register.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // Output register: the pending result moves here once the output is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_EMIT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT) && out_free) begin
            m_item_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    // A ring memory read always completes in the following cycle.
    a_fetch_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |=> (state_reg == ST_EMIT))
        else $error("fetch state did not advance to emit");

    // A pending result is never overwritten while the output register is still full.
    a_no_result_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_valid_reg && !m_ready) |=> (state_reg == ST_EMIT))
        else $error("pending result dropped while output stalled");

    // No ring is written when it is full.
    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !((tx_we && tx_full) || (rx_we && rx_full)))
        else $error("ring written while full");

    // No ring is popped when it is empty.
    a_no_read_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !((tx_re && tx_empty) || (rx_re && rx_empty)))
        else $error("ring popped while empty");

    // A mailbox load always leaves the mailbox busy.
    a_mbox_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (res_next.kind == KIND_LOADED)) |=> mbox_busy_reg)
        else $error("mailbox not busy after load");
`endif

endmodule

### rtl/canmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module canmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### test/can_message_queue_engine_core_test.sv
// Self-checking testbench for the CAN message queue engine: directed table, then random traffic.
`timescale 1ns / 100ps

module can_message_queue_engine_core_test;
    import canmq_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 7;
    localparam int TX_SLOTS = TX_DEPTH_DEF;
    localparam int RX_SLOTS = RX_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;

    // Traffic profiles that push the rings toward full or empty.
    typedef enum int {
        TRAFFIC_MIXED,
        TRAFFIC_FILL_TX,
        TRAFFIC_DRAIN_TX,
        TRAFFIC_FILL_RX,
        TRAFFIC_DRAIN_RX
    } traffic_t;

    // One row of the directed table; the result is used only when it is typed in.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int        error_count;
    int        cycle_count;
    int        sender_idle_pct;
    int        receiver_idle_pct;
    bit        hold_request;
    int        hold_left;
    out_item_t pending_results[$];
    stim_row_t directed_rows[$];

    // Mirror of the queue engine state.
    hdr_t        tx_hdr_mem[TX_SLOTS];
    logic [63:0] tx_pay_mem[TX_SLOTS];
    hdr_t        rx_hdr_mem[RX_SLOTS];
    logic [63:0] rx_pay_mem[RX_SLOTS];
    int          tx_wr;
    int          tx_rd;
    int          rx_wr;
    int          rx_rd;
    bit          mailbox_taken;
    bit          rx_dropped;
    bit          tx_dropped;

    can_message_queue_engine_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #(HALF_PERIOD) aclk = ~aclk;

    // Watchdog against a hung handshake.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Print one mismatch line and count it.
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Mailbox identifier word: standard ids lose all but their low 11 bits.
    function automatic logic [31:0] mailbox_word(input hdr_t h);
        logic [31:0] w;
        if (h.extended) begin
            w = {h.ident, 3'b100};
        end else begin
            w = {h.ident[10:0], 21'd0};
        end
        if (h.remote) begin
            w[1] = 1'b1;
        end
        w[0] = 1'b1;
        return w;
    endfunction

    // Message fields of a result; everything else stays zero.
    function automatic out_item_t message_result(input logic [2:0] kind, input hdr_t h,
                                                 input logic [63:0] pay);
        out_item_t r;
        r = '0;
        r.kind = kind;
        r.out_ident = h.ident;
        r.out_extended = h.extended;
        r.out_remote = h.remote;
        r.out_length = h.length;
        r.out_data_low = pay[31:0];
        r.out_data_high = pay[63:32];
        return r;
    endfunction

    // Advance the mirrored state by one transaction and return the result it causes.
    function automatic out_item_t queue_engine_step(input in_item_t it);
        out_item_t   r;
        hdr_t        h;
        logic [63:0] pay;
        int          nxt;
        r = '0;
        pay = {it.data_high, it.data_low};
        case (it.action)
            ACT_SEND: begin
                h.ident = it.ident;
                h.extended = it.extended;
                h.remote = it.remote;
                h.length = it.length;
                if (!mailbox_taken) begin
                    mailbox_taken = 1'b1;
                    r = message_result(KIND_LOADED, h, pay);
                    r.ident_word = mailbox_word(h);
                end else begin
                    nxt = (tx_wr + 1) % TX_SLOTS;
                    if (nxt == tx_rd) begin
                        tx_dropped = 1'b1;
                    end else begin
                        tx_hdr_mem[tx_wr] = h;
                        tx_pay_mem[tx_wr] = pay;
                        tx_wr = nxt;
                    end
                    r.kind = KIND_QUEUED;
                end
            end
            ACT_TX_DONE: begin
                if (tx_wr != tx_rd) begin
                    h = tx_hdr_mem[tx_rd];
                    pay = tx_pay_mem[tx_rd];
                    tx_rd = (tx_rd + 1) % TX_SLOTS;
                    mailbox_taken = 1'b1;
                    r = message_result(KIND_LOADED, h, pay);
                    r.ident_word = mailbox_word(h);
                end else begin
                    mailbox_taken = 1'b0;
                    r.kind = KIND_NOTHING;
                end
            end
            ACT_RECEIVE: begin
                h.extended = it.raw_id_word[2];
                h.remote = it.raw_id_word[1];
                h.length = it.length;
                if (it.raw_id_word[2]) begin
                    h.ident = it.raw_id_word[31:3];
                end else begin
                    h.ident = {18'd0, it.raw_id_word[31:21]};
                end
                nxt = (rx_wr + 1) % RX_SLOTS;
                if (nxt == rx_rd) begin
                    rx_dropped = 1'b1;
                end else begin
                    rx_hdr_mem[rx_wr] = h;
                    rx_pay_mem[rx_wr] = pay;
                    rx_wr = nxt;
                end
                r.kind = KIND_STORED;
            end
            default: begin
                if (rx_wr != rx_rd) begin
                    h = rx_hdr_mem[rx_rd];
                    pay = rx_pay_mem[rx_rd];
                    rx_rd = (rx_rd + 1) % RX_SLOTS;
                    r = message_result(KIND_READ, h, pay);
                end else begin
                    r.kind = KIND_EMPTY;
                end
            end
        endcase
        r.rx_overflow = rx_dropped;
        r.tx_overflow = tx_dropped;
        return r;
    endfunction

    // Transaction builders for the table.
    function automatic in_item_t send_item(input logic [28:0] ident, input logic ext,
                                           input logic rem, input logic [3:0] len,
                                           input logic [31:0] dl, input logic [31:0] dh);
        in_item_t it;
        it = '0;
        it.action = ACT_SEND;
        it.ident = ident;
        it.extended = ext;
        it.remote = rem;
        it.length = len;
        it.data_low = dl;
        it.data_high = dh;
        return it;
    endfunction

    function automatic in_item_t receive_item(input logic [31:0] raw, input logic [3:0] len,
                                              input logic [31:0] dl, input logic [31:0] dh);
        in_item_t it;
        it = '0;
        it.action = ACT_RECEIVE;
        it.raw_id_word = raw;
        it.length = len;
        it.data_low = dl;
        it.data_high = dh;
        return it;
    endfunction

    function automatic in_item_t op_item(input logic [1:0] action);
        in_item_t it;
        it = '0;
        it.action = action;
        return it;
    endfunction

    // Result with only a kind; flags are still clear in the directed part.
    function automatic out_item_t kind_only(input logic [2:0] kind);
        out_item_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    task automatic add_row(input in_item_t item, input bit typed, input out_item_t result);
        stim_row_t row;
        row.item = item;
        row.typed = typed;
        row.result = result;
        directed_rows.push_back(row);
    endtask

    // Choose an action biased by the traffic profile.
    function automatic logic [1:0] pick_action(input traffic_t mode);
        int roll;
        roll = $urandom_range(99);
        case (mode)
            TRAFFIC_FILL_TX:
                return roll < 80 ? ACT_SEND : roll < 88 ? ACT_TX_DONE :
                       roll < 94 ? ACT_RECEIVE : ACT_READ;
            TRAFFIC_DRAIN_TX:
                return roll < 65 ? ACT_TX_DONE : roll < 80 ? ACT_SEND :
                       roll < 90 ? ACT_RECEIVE : ACT_READ;
            TRAFFIC_FILL_RX:
                return roll < 80 ? ACT_RECEIVE : roll < 88 ? ACT_READ :
                       roll < 94 ? ACT_SEND : ACT_TX_DONE;
            TRAFFIC_DRAIN_RX:
                return roll < 65 ? ACT_READ : roll < 80 ? ACT_RECEIVE :
                       roll < 90 ? ACT_SEND : ACT_TX_DONE;
            default:
                return 2'($urandom_range(3));
        endcase
    endfunction

    // Random transaction; every field is filled whatever the action.
    function automatic in_item_t random_item(input traffic_t mode);
        in_item_t    it;
        logic [31:0] word;
        it.action = pick_action(mode);
        word = $urandom();
        it.ident = word[28:0];
        // Now and then a plain 11-bit identifier, as software usually sends.
        if ($urandom_range(3) == 0) begin
            it.ident = {18'd0, word[10:0]};
        end
        it.extended = 1'($urandom_range(1));
        it.remote = 1'($urandom_range(1));
        it.length = 4'($urandom_range(15));
        it.data_low = $urandom();
        it.data_high = $urandom();
        it.raw_id_word = $urandom();
        return it;
    endfunction

    // Offer one transaction and record its expected result once it is accepted.
    task automatic offer(input in_item_t item, input bit typed, input out_item_t typed_result);
        out_item_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = queue_engine_step(item);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            report_error($sformatf("result with nothing pending, kind %0d", got.kind));
        end else begin
            want = pending_results.pop_front();
            compare_field("kind", 64'(got.kind), 64'(want.kind));
            compare_field("ident_word", 64'(got.ident_word), 64'(want.ident_word));
            compare_field("out_ident", 64'(got.out_ident), 64'(want.out_ident));
            compare_field("out_extended", 64'(got.out_extended), 64'(want.out_extended));
            compare_field("out_remote", 64'(got.out_remote), 64'(want.out_remote));
            compare_field("out_length", 64'(got.out_length), 64'(want.out_length));
            compare_field("out_data_low", 64'(got.out_data_low), 64'(want.out_data_low));
            compare_field("out_data_high", 64'(got.out_data_high),
                          64'(want.out_data_high));
            compare_field("rx_overflow", 64'(got.rx_overflow), 64'(want.rx_overflow));
            compare_field("tx_overflow", 64'(got.tx_overflow), 64'(want.tx_overflow));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_item);
        end
    end

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Main sequence: reset, directed table, three random phases, drain.
    initial begin
        out_item_t expected;
        traffic_t  mode;
        int        burst;
        int        done_in_phase;
        int        phase_items;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        error_count = 0;
        hold_request = 1'b0;
        sender_idle_pct = 28;
        receiver_idle_pct = 61;
        tx_wr = 0;
        tx_rd = 0;
        rx_wr = 0;
        rx_rd = 0;
        mailbox_taken = 1'b0;
        rx_dropped = 1'b0;
        tx_dropped = 1'b0;

        // Directed table: reset state, extremes, masking, empty rings.
        add_row(op_item(ACT_READ), 1'b1, kind_only(KIND_EMPTY));
        add_row(op_item(ACT_TX_DONE), 1'b1, kind_only(KIND_NOTHING));
        expected = kind_only(KIND_LOADED);
        expected.ident_word = 32'hFFE0_0001;
        expected.out_ident = 29'h7FF;
        expected.out_length = 4'd8;
        expected.out_data_low = 32'hFFFF_FFFF;
        expected.out_data_high = 32'hFFFF_FFFF;
        add_row(send_item(29'h7FF, 1'b0, 1'b0, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                1'b1, expected);
        add_row(send_item(29'h1FFF_FFFF, 1'b1, 1'b1, 4'd15, 32'd0, 32'd0),
                1'b1, kind_only(KIND_QUEUED));
        // Standard identifier with bits above the low 11 set.
        add_row(send_item(29'h1555_5555, 1'b0, 1'b1, 4'd0, 32'h1234_5678, 32'h9ABC_DEF0),
                1'b1, kind_only(KIND_QUEUED));
        add_row(send_item(29'h0, 1'b1, 1'b0, 4'd1, 32'hA5A5_A5A5, 32'h5A5A_5A5A),
                1'b1, kind_only(KIND_QUEUED));
        add_row(op_item(ACT_TX_DONE), 1'b0, '0);
        add_row(op_item(ACT_TX_DONE), 1'b0, '0);
        add_row(op_item(ACT_TX_DONE), 1'b0, '0);
        add_row(op_item(ACT_TX_DONE), 1'b1, kind_only(KIND_NOTHING));
        // Transmit done while the mailbox is already free.
        add_row(op_item(ACT_TX_DONE), 1'b1, kind_only(KIND_NOTHING));
        add_row(send_item(29'h1FFF_FFFF, 1'b0, 1'b0, 4'd15, 32'h0, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(op_item(ACT_TX_DONE), 1'b1, kind_only(KIND_NOTHING));
        add_row(receive_item(32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                1'b1, kind_only(KIND_STORED));
        add_row(receive_item(32'h0, 4'd0, 32'h0, 32'h0), 1'b1, kind_only(KIND_STORED));
        add_row(receive_item(32'hFFE0_0002, 4'd5, 32'hA5A5_5A5A, 32'h0F0F_F0F0),
                1'b1, kind_only(KIND_STORED));
        add_row(receive_item(32'h0000_0004, 4'd9, 32'h0000_0001, 32'h8000_0000),
                1'b1, kind_only(KIND_STORED));
        repeat (4) add_row(op_item(ACT_READ), 1'b0, '0);
        add_row(op_item(ACT_READ), 1'b1, kind_only(KIND_EMPTY));

        // Synchronous reset for a fixed number of cycles.
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        end

        // Random phases: sender-light idling, then receiver-light, then none.
        phase_items = RANDOM_ITEMS / 3;
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 61 : 0;
            receiver_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 28 : 0;
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            done_in_phase = 0;
            while (done_in_phase < phase_items) begin
                mode = traffic_t'($urandom_range(4));
                burst = $urandom_range(20, 60);
                for (int k = 0; k < burst && done_in_phase < phase_items; k++) begin
                    offer(random_item(mode), 1'b0, '0);
                    done_in_phase++;
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // Wait for every expected result, then a little longer for strays.
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
